>>> hdl/bxt_pkg.sv
// bxt_pkg: shared types and constants for the binary xor trie unit
// no dependencies; imported by the controller, the datapath and the top level
package bxt_pkg;

  // field widths fixed by the item format
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 20;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MAXQ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_MINQ   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POOL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT  = 3'd4;

  // kind of trie walk step the datapath performs in a cycle
  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_CHECK,
    WALK_MODIFY,
    WALK_QUERY
  } walk_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                rewind;
    walk_t               walk;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_insert;
    logic is_erase;
    logic is_query;
    logic count_full;
    logic empty;
    logic stop;
    logic last;
    logic miss;
    logic pool_short;
  } sts_t;

endpackage

>>> hdl/bxt_ram.sv
// bxt_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bxt_ctrl.sv
// bxt_ctrl: sequencing state machine of the binary xor trie unit
// depends on bxt_pkg for the command and status structs and the status codes
module bxt_ctrl
  import bxt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_MODIFY = 3'd4;
  localparam logic [2:0] S_QUERY  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] fin_status_r, fin_status_nxt;
  logic                out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    fin_status_nxt = fin_status_r;
    cmd            = '0;
    cmd.walk       = WALK_NONE;
    cmd.status     = fin_status_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.is_insert && sts.count_full) begin
          fin_status_nxt = ST_COUNT;
          state_nxt      = S_FIN;
        end else if (sts.is_query && sts.empty) begin
          fin_status_nxt = ST_EMPTY;
          state_nxt      = S_FIN;
        end else if (sts.is_query) begin
          state_nxt = S_QUERY;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.walk = WALK_CHECK;
        if (sts.stop || sts.last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_erase && sts.miss) begin
          fin_status_nxt = ST_ABSENT;
          state_nxt      = S_FIN;
        end else if (sts.is_insert && sts.pool_short) begin
          fin_status_nxt = ST_POOL;
          state_nxt      = S_FIN;
        end else begin
          cmd.rewind = 1'b1;
          state_nxt  = S_MODIFY;
        end
      end
      S_MODIFY: begin
        cmd.walk = WALK_MODIFY;
        if (sts.last) begin
          fin_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end
      end
      S_QUERY: begin
        cmd.walk = WALK_QUERY;
        if (sts.last) begin
          fin_status_nxt = ST_OK;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register valid flag
  always_comb begin
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fin_status_r <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fin_status_r <= fin_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/bxt_dpath.sv
// bxt_dpath: trie walker datapath with root registers, node memory and result register
// depends on bxt_pkg and bxt_ram; driven by bxt_ctrl through cmd_t and sts_t
module bxt_dpath
  import bxt_pkg::*;
#(
  parameter int KEY_BITS  = 31,
  parameter int NODE_POOL = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [KEY_BITS-1:0] in_key,
  output sts_t                sts,
  output logic [KEY_BITS-1:0] res_xor,
  output logic [STATUS_W-1:0] res_status
);

  localparam int NW    = $clog2(NODE_POOL);
  localparam int LW    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NDW   = $clog2(KEY_BITS + 1);
  localparam int REC_W = 2 * NW + 2 * CNT_W;

  // latched item and walk state
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [NW-1:0]       cur_addr_r, cur_addr_nxt;
  logic                at_root_r, at_root_nxt;
  logic                fresh_r, fresh_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [NDW-1:0]      needed_r, needed_nxt;
  logic                miss_r, miss_nxt;

  // global trie state
  logic [NW:0]         next_free_r, next_free_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [NW-1:0]       root_zc_r, root_zc_nxt;
  logic [NW-1:0]       root_oc_r, root_oc_nxt;
  logic [CNT_W-1:0]    root_zn_r, root_zn_nxt;
  logic [CNT_W-1:0]    root_on_r, root_on_nxt;

  // result register
  logic [KEY_BITS-1:0] res_xor_r, res_xor_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  // node record of the current node and its updated copy
  logic [NW-1:0]       cur_zc, cur_oc, new_zc, new_oc;
  logic [CNT_W-1:0]    cur_zn, cur_on, new_zn, new_on;
  logic [REC_W-1:0]    ram_rdata, ram_wdata;
  logic                ram_we, ram_re;
  logic [NW-1:0]       nxt_addr;

  logic                kbit, pref, take, alloc, stop, is_ins, is_max;
  logic [NW-1:0]       child_b, child_p, child_alt, new_child;
  logic [CNT_W-1:0]    cnt_b, cnt_p, cnt_new;
  logic [NW+1:0]       pool_sum;

  assign is_ins = (act_r == ACT_INSERT);
  assign is_max = (act_r == ACT_MAXQ);

  // current record: root registers, a fresh zero node or memory read data
  always_comb begin
    if (at_root_r) begin
      cur_zc = root_zc_r;
      cur_oc = root_oc_r;
      cur_zn = root_zn_r;
      cur_on = root_on_r;
    end else if (fresh_r) begin
      cur_zc = '0;
      cur_oc = '0;
      cur_zn = '0;
      cur_on = '0;
    end else begin
      {cur_zc, cur_oc, cur_zn, cur_on} = ram_rdata;
    end
  end

  // per-level child selection
  always_comb begin
    kbit      = key_r[lvl_r];
    child_b   = kbit ? cur_oc : cur_zc;
    cnt_b     = kbit ? cur_on : cur_zn;
    pref      = is_max ? ~kbit : kbit;
    child_p   = pref ? cur_oc : cur_zc;
    cnt_p     = pref ? cur_on : cur_zn;
    child_alt = pref ? cur_zc : cur_oc;
    take      = (child_p != '0) && (cnt_p != '0);
    alloc     = fresh_r || (child_b == '0);
    new_child = alloc ? next_free_r[NW-1:0] : child_b;
    cnt_new   = is_ins ? cnt_b + CNT_W'(1) : cnt_b - CNT_W'(1);
    stop      = (child_b == '0) || (!is_ins && (cnt_b == '0));
    pool_sum  = {1'b0, next_free_r} + (NW + 2)'(needed_r);
  end

  // updated record for a modify step
  always_comb begin
    new_zc = cur_zc;
    new_oc = cur_oc;
    new_zn = cur_zn;
    new_on = cur_on;
    if (kbit) begin
      new_oc = is_ins ? new_child : cur_oc;
      new_on = cnt_new;
    end else begin
      new_zc = is_ins ? new_child : cur_zc;
      new_zn = cnt_new;
    end
  end

  // walk sequencing and state updates
  always_comb begin
    key_nxt        = key_r;
    act_nxt        = act_r;
    lvl_nxt        = lvl_r;
    cur_addr_nxt   = cur_addr_r;
    at_root_nxt    = at_root_r;
    fresh_nxt      = fresh_r;
    acc_nxt        = acc_r;
    needed_nxt     = needed_r;
    miss_nxt       = miss_r;
    next_free_nxt  = next_free_r;
    total_nxt      = total_r;
    root_zc_nxt    = root_zc_r;
    root_oc_nxt    = root_oc_r;
    root_zn_nxt    = root_zn_r;
    root_on_nxt    = root_on_r;
    res_xor_nxt    = res_xor_r;
    res_status_nxt = res_status_r;
    nxt_addr       = child_b;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (cmd.load) begin
      key_nxt     = in_key;
      act_nxt     = in_action;
      acc_nxt     = '0;
      needed_nxt  = '0;
      miss_nxt    = 1'b0;
    end
    if (cmd.load || cmd.rewind) begin
      lvl_nxt      = LW'(KEY_BITS - 1);
      at_root_nxt  = 1'b1;
      fresh_nxt    = 1'b0;
      cur_addr_nxt = '0;
    end

    case (cmd.walk)
      WALK_CHECK: begin
        ram_re = 1'b1;
        if (stop) begin
          miss_nxt   = 1'b1;
          needed_nxt = NDW'(lvl_r) + NDW'(1);
        end
      end
      WALK_MODIFY: begin
        ram_re   = 1'b1;
        nxt_addr = new_child;
        ram_we   = !at_root_r;
        if (at_root_r) begin
          root_zc_nxt = new_zc;
          root_oc_nxt = new_oc;
          root_zn_nxt = new_zn;
          root_on_nxt = new_on;
        end
        if (is_ins && alloc) begin
          next_free_nxt = next_free_r + (NW + 1)'(1);
          fresh_nxt     = 1'b1;
        end
      end
      WALK_QUERY: begin
        ram_re          = 1'b1;
        nxt_addr        = take ? child_p : child_alt;
        acc_nxt[lvl_r]  = is_max ? take : ~take;
      end
      default: begin
      end
    endcase

    // step down one level
    if (cmd.walk != WALK_NONE) begin
      cur_addr_nxt = nxt_addr;
      at_root_nxt  = 1'b0;
      lvl_nxt      = lvl_r - LW'(1);
    end

    // commit the result and the stored key total
    if (cmd.finish) begin
      res_status_nxt = cmd.status;
      res_xor_nxt    = (cmd.status == ST_OK && !is_ins && act_r != ACT_ERASE) ? acc_r : '0;
      if (cmd.status == ST_OK && is_ins) begin
        total_nxt = total_r + CNT_W'(1);
      end else if (cmd.status == ST_OK && act_r == ACT_ERASE) begin
        total_nxt = total_r - CNT_W'(1);
      end
    end
  end

  assign ram_wdata = {new_zc, new_oc, new_zn, new_on};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= (NW + 1)'(1);
      total_r     <= '0;
      root_zc_r   <= '0;
      root_oc_r   <= '0;
      root_zn_r   <= '0;
      root_on_r   <= '0;
      at_root_r   <= 1'b1;
      fresh_r     <= 1'b0;
      miss_r      <= 1'b0;
      lvl_r       <= '0;
    end else begin
      next_free_r <= next_free_nxt;
      total_r     <= total_nxt;
      root_zc_r   <= root_zc_nxt;
      root_oc_r   <= root_oc_nxt;
      root_zn_r   <= root_zn_nxt;
      root_on_r   <= root_on_nxt;
      at_root_r   <= at_root_nxt;
      fresh_r     <= fresh_nxt;
      miss_r      <= miss_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    act_r        <= act_nxt;
    cur_addr_r   <= cur_addr_nxt;
    acc_r        <= acc_nxt;
    needed_r     <= needed_nxt;
    res_xor_r    <= res_xor_nxt;
    res_status_r <= res_status_nxt;
  end

  // node memory: {zero child, one child, zero count, one count} per node
  bxt_ram #(
    .WIDTH (REC_W),
    .DEPTH (NODE_POOL)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (nxt_addr),
    .rdata (ram_rdata)
  );

  // status towards the controller
  always_comb begin
    sts.is_insert  = is_ins;
    sts.is_erase   = (act_r == ACT_ERASE);
    sts.is_query   = (act_r == ACT_MAXQ) || (act_r == ACT_MINQ);
    sts.count_full = (total_r == COUNT_MAX);
    sts.empty      = (total_r == '0);
    sts.stop       = stop;
    sts.last       = (lvl_r == '0);
    sts.miss       = miss_r;
    sts.pool_short = (pool_sum > (NW + 2)'(NODE_POOL));
  end

  assign res_xor    = res_xor_r;
  assign res_status = res_status_r;

endmodule

>>> hdl/binary_xor_trie_unit.sv
// binary_xor_trie_unit: top level of the binary xor trie (insert, erase, max/min xor query)
// depends on bxt_pkg, bxt_ctrl, bxt_dpath and bxt_ram
//
// usage
// - input channel in_*: one request per item, in_tuser carries the action, in_tdata the key
// - result channel out_*: exactly one result per request, in request order; out_tdata
//   carries the best xor (zero for insert, erase and any failing request), out_tuser
//   the status code
// - one request is handled at a time; in_tready is high only while the unit is idle
// - a query makes one walk down the trie before its result; insert and erase make a
//   checking walk, then an updating walk; requests rejected before any walk go straight
//   to the result
// - the walk speed is set by the node memory: each trie level costs one dependent read
//   of its single read port
// - the result sits in an output register; the next request is taken while it waits,
//   and the unit only holds its following result while the receiver stalls
// - after reset the trie is empty and the pool is full of free nodes; no clearing
//   pass is needed, since the root lives in registers and freshly allocated nodes
//   are treated as zero until written
module binary_xor_trie_unit
  import bxt_pkg::*;
#(
  parameter int KEY_BITS  = 31,
  parameter int NODE_POOL = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [KEY_BITS-1:0] key, upper bits zero
  input  logic [((KEY_BITS + 7) / 8) * 8-1:0] in_tdata,
  // [1:0] action
  input  logic [ACT_W-1:0]                    in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [KEY_BITS-1:0] xor_value, upper bits zero
  output logic [((KEY_BITS + 7) / 8) * 8-1:0] out_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]                 out_tuser
);

  localparam int DW = ((KEY_BITS + 7) / 8) * 8;

  cmd_t                cmd;
  sts_t                sts;
  logic [KEY_BITS-1:0] res_xor;
  logic [STATUS_W-1:0] res_status;

  // sequencing
  bxt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  // trie walker
  bxt_dpath #(
    .KEY_BITS  (KEY_BITS),
    .NODE_POOL (NODE_POOL)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_action  (in_tuser),
    .in_key     (in_tdata[KEY_BITS-1:0]),
    .sts        (sts),
    .res_xor    (res_xor),
    .res_status (res_status)
  );

  // result packing
  assign out_tdata = DW'(res_xor);
  assign out_tuser = res_status;

  // one request at a time: no second acceptance right after one
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a failing status never carries an xor value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("non-zero xor value with failing status");

  // a result is only loaded when the output register is free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_tvalid || out_tready)
    else $error("result register overwritten before it was taken");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_COUNT)
    else $error("status code outside the defined set");

endmodule
